[sv/bpg_pkg.sv]
// Shared constants for the backtracking permutation generator.
// No dependencies; imported by the top level and by its port checker.
package bpg_pkg;

    localparam int MAX_SET_DEF = 8;            // default largest set size
    localparam int VAL_W       = 4;            // symbol / result value width
    localparam int SIZE_W      = 4;            // set_size register width
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd3;

endpackage

[sv/backtracking_permutation_generator_top.sv]
// Backtracking permutation generator, top level with its search sequencer.
// Depends on bpg_pkg (widths, defaults). Checker is bound in bpg_checker.sv.
//
// Usage:
//   cfg channel  : cfg_valid/cfg_ready with cfg_set_size, the symbol count n
//                  (0 acts as 1, values above MAX_SET act as MAX_SET). Every
//                  write also restarts the enumeration. Taken only while idle.
//   s channel    : one request per transfer; s_restart = 1 restarts the
//                  enumeration first, 0 continues from the last permutation.
//   m channel    : n transfers per request, m_value = symbols in order,
//                  m_last on the n-th. Once every permutation has been given,
//                  a request yields one transfer with m_exhausted = 1,
//                  m_last = 1 and m_value = 0, and keeps doing so until a
//                  restart or a configuration write.
// Sequencing: one request is searched at a time by a single sequencer around
//   the option-stack RAM (one read and one write port). A descent steps once,
//   reads the top of each upper level into the used mask, then pushes each
//   unused candidate; a backtrack steps and then pops. Each output value is a
//   RAM read, then a register load.
// s_ready is high only while the sequencer is idle. A stalled receiver holds
//   the output register and the sequencer waits; the final transfer may still
//   be pending when the next request is accepted.
// Reset (aresetn low, synchronous): set size 3, enumeration restarted, output
//   register empty. The option-stack RAM is not cleared.
module backtracking_permutation_generator_top #(
    parameter int MAX_SET = bpg_pkg::MAX_SET_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bpg_pkg::SIZE_W-1:0] cfg_set_size,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_restart,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bpg_pkg::VAL_W-1:0]  m_value,
    output logic                       m_last,
    output logic                       m_exhausted
);
    import bpg_pkg::*;

    localparam int LEVELS = MAX_SET + 2;            // levels 0 .. n+1
    localparam int SLOTS  = MAX_SET + 1;            // slot 0 unused
    localparam int LW     = $clog2(LEVELS);         // level index
    localparam int CW     = $clog2(SLOTS);          // stack fill / symbol index
    localparam int DEPTH  = LEVELS * SLOTS;
    localparam int AW     = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,        // descend or backtrack one level
        S_POP,         // after moving up: drop the tried option
        S_SCAN,        // read top of an upper level
        S_SCAN_WAIT,   // collect it into the used mask
        S_PUSH,        // try one candidate per cycle, push it if unused
        S_EMIT_RD,     // read top of level lvl for output
        S_EMIT_WAIT,   // load output register
        S_EXH          // load exhausted result
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg [LEVELS];
    logic [LW-1:0]       depth_reg;
    logic                done_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [LW-1:0]       lvl_reg;
    logic [CW-1:0]       cand_reg;
    logic [SLOTS-1:0]    used_reg;
    logic                m_valid_reg;
    logic [VAL_W-1:0]    m_value_reg;
    logic                m_last_reg;
    logic                m_exh_reg;

    // option stack RAM
    logic [VAL_W-1:0]    stack_mem [DEPTH];
    logic [VAL_W-1:0]    rdata_reg;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;

    logic [CW-1:0]       n_eff;
    logic [LW-1:0]       cnt_idx;
    logic [CW-1:0]       cnt_sel;
    logic [LW-1:0]       up_lvl;
    logic [LW-1:0]       dn_lvl;
    logic                out_free;
    logic                out_load;
    logic                clear_search;
    logic [SLOTS-1:0]    hit_mask;

    // clamp set size into 1..MAX_SET
    always_comb begin
        if (size_reg == '0) begin
            n_eff = CW'(1);
        end else if (32'(size_reg) > MAX_SET) begin
            n_eff = CW'(MAX_SET);
        end else begin
            n_eff = CW'(size_reg);
        end
    end

    // single read port on the fill counters; the emit read address stays put
    // while the output waits, so the read data holds its symbol
    assign cnt_idx = (state_reg == S_SCAN || state_reg == S_EMIT_RD ||
                      state_reg == S_EMIT_WAIT) ? lvl_reg : depth_reg;
    assign cnt_sel = count_reg[cnt_idx];

    assign up_lvl = (depth_reg == LW'(LEVELS - 1)) ? depth_reg : depth_reg + LW'(1);
    assign dn_lvl = (depth_reg == '0) ? depth_reg : depth_reg - LW'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = out_free && (state_reg == S_EMIT_WAIT || state_reg == S_EXH);
    assign hit_mask = SLOTS'(1) << rdata_reg;

    assign rd_addr = AW'(lvl_reg) * AW'(SLOTS) + AW'(cnt_sel);
    assign wr_addr = AW'(depth_reg) * AW'(SLOTS) + AW'(cnt_sel) + AW'(1);
    assign wr_en   = (state_reg == S_PUSH) && !used_reg[cand_reg];

    assign cfg_ready    = (state_reg == S_IDLE);
    assign s_ready      = (state_reg == S_IDLE);
    assign clear_search = (state_reg == S_IDLE) &&
                          ((cfg_valid) || (s_valid && s_restart));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= VAL_W'(cand_reg);
        end
        rdata_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            for (int k = 0; k < LEVELS; k++) begin
                count_reg[k] <= (k == 0) ? CW'(1) : '0;
            end
            depth_reg   <= '0;
            done_reg    <= 1'b0;
            size_reg    <= SIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cfg_valid) begin
                        size_reg <= cfg_set_size;
                    end
                    if (clear_search) begin
                        for (int k = 0; k < LEVELS; k++) begin
                            count_reg[k] <= (k == 0) ? CW'(1) : '0;
                        end
                        depth_reg <= '0;
                        done_reg  <= 1'b0;
                    end
                    if (s_valid) begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (done_reg || count_reg[0] == '0) begin
                        state_reg <= S_EXH;
                    end else if (cnt_sel != '0) begin
                        depth_reg         <= up_lvl;
                        count_reg[up_lvl] <= '0;
                        lvl_reg           <= LW'(1);
                        used_reg          <= '0;
                        cand_reg          <= n_eff;
                        if (up_lvl == LW'(n_eff) + LW'(1)) begin
                            state_reg <= S_EMIT_RD;
                        end else if (up_lvl > LW'(1)) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_PUSH;
                        end
                    end else begin
                        depth_reg <= dn_lvl;
                        state_reg <= S_POP;
                    end
                end
                S_POP: begin
                    if (cnt_sel != '0) begin
                        count_reg[depth_reg] <= cnt_sel - CW'(1);
                    end
                    state_reg <= S_STEP;
                end
                S_SCAN: begin
                    state_reg <= S_SCAN_WAIT;
                end
                S_SCAN_WAIT: begin
                    used_reg <= used_reg | hit_mask;
                    if (lvl_reg + LW'(1) < depth_reg) begin
                        lvl_reg   <= lvl_reg + LW'(1);
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!used_reg[cand_reg]) begin
                        count_reg[depth_reg] <= cnt_sel + CW'(1);
                    end
                    if (cand_reg == CW'(1)) begin
                        state_reg <= S_STEP;
                    end else begin
                        cand_reg <= cand_reg - CW'(1);
                    end
                end
                S_EMIT_RD: begin
                    state_reg <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (out_free) begin
                        m_value_reg <= rdata_reg;
                        m_last_reg  <= (lvl_reg == LW'(n_eff));
                        m_exh_reg   <= 1'b0;
                        if (lvl_reg == LW'(n_eff)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            lvl_reg   <= lvl_reg + LW'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                S_EXH: begin
                    if (out_free) begin
                        m_value_reg <= '0;
                        m_last_reg  <= 1'b1;
                        m_exh_reg   <= 1'b1;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_last      = m_last_reg;
    assign m_exhausted = m_exh_reg;

endmodule

[sv/bpg_checker.sv]
// Port-level checks for the permutation generator, bound to the top level.
// Depends on bpg_pkg for port widths.
module bpg_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_ready,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [bpg_pkg::VAL_W-1:0]  m_value,
    input logic                       m_last,
    input logic                       m_exhausted
);
    import bpg_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_last)
                                && $stable(m_exhausted))
        else $error("result changed while stalled");

    // exhausted result is a single zero transfer
    a_exh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_exhausted |-> m_last && m_value == '0)
        else $error("malformed exhausted result");

    // permutation symbols are never zero
    a_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_exhausted |-> m_value != '0)
        else $error("zero symbol in permutation");

    // one request at a time: busy right after a request transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !cfg_ready)
        else $error("ready right after a request transfer");

    // after reset: idle and empty
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> s_ready && cfg_ready && !m_valid)
        else $error("not idle after reset");

endmodule

bind backtracking_permutation_generator_top bpg_checker u_bpg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_ready    (cfg_ready),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_value      (m_value),
    .m_last       (m_last),
    .m_exhausted  (m_exhausted)
);

[tb/backtracking_permutation_generator_top_test.sv]
// Self-checking testbench for the backtracking permutation generator top level.
// Depends on bpg_pkg and backtracking_permutation_generator_top; it predicts
// every result transfer and compares each one with what the block sends.
module backtracking_permutation_generator_top_test;

    import bpg_pkg::*;

    localparam int LEVELS = MAX_SET_DEF + 2;   // stack levels, incl. the root
    localparam int SLOTS  = MAX_SET_DEF + 1;   // entries per level, slot 0 unused
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 36;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             exhausted;
    } perm_beat_t;

    // Scoreboard: runs its own copy of the search and queues the expected
    // transfers for every accepted request, then checks what comes out.
    class perm_scoreboard;
        logic [3:0]        lvl_cnt [LEVELS];
        logic [VAL_W-1:0]  opt     [LEVELS][SLOTS];
        int unsigned       depth;
        bit                finished;
        logic [SIZE_W-1:0] size_reg;
        perm_beat_t        expected_q[$];
        int errors, requests, restarts, perms, exhausts, beats, cfg_writes;

        function new();
            size_reg = SIZE_RESET;
            clear_search();
        endfunction

        function int unsigned eff_size();
            if (size_reg == 0) return 1;
            if (size_reg > MAX_SET_DEF) return MAX_SET_DEF;
            return 32'(size_reg);
        endfunction

        function logic [VAL_W-1:0] top_sym(int unsigned lvl);
            return opt[lvl % LEVELS][lvl_cnt[lvl % LEVELS] % SLOTS];
        endfunction

        function void clear_search();
            foreach (lvl_cnt[l]) begin
                lvl_cnt[l] = '0;
                foreach (opt[l][s]) opt[l][s] = '0;
            end
            lvl_cnt[0] = 4'd1;
            depth      = 0;
            finished   = 1'b0;
        endfunction

        // candidates go on largest first, so the top is the smallest untried one
        function void push_symbols(int unsigned lvl, int unsigned n);
            int  cand;
            int  above;
            bit  used;
            for (cand = n; cand >= 1; cand--) begin
                used = 1'b0;
                for (above = 1; above < lvl; above++)
                    if (top_sym(above) == cand) used = 1'b1;
                if (!used) begin
                    lvl_cnt[lvl] = lvl_cnt[lvl] + 4'd1;
                    opt[lvl][lvl_cnt[lvl] % SLOTS] = VAL_W'(cand);
                end
            end
        endfunction

        function void note_config(logic [SIZE_W-1:0] sz);
            size_reg = sz;
            cfg_writes++;
            clear_search();
        endfunction

        function void note_request(bit rst);
            int unsigned n;
            int unsigned d;
            int unsigned i;
            perm_beat_t  beat;
            n = eff_size();
            requests++;
            if (rst) begin
                restarts++;
                clear_search();
            end
            while (!finished && lvl_cnt[0] > 0) begin
                d = depth % LEVELS;
                if (lvl_cnt[d] > 0) begin
                    // descend one level
                    d = d + 1;
                    if (d >= LEVELS) d = LEVELS - 1;
                    depth      = d;
                    lvl_cnt[d] = '0;
                    if (d == n + 1) begin
                        for (i = 1; i <= n; i++) begin
                            beat.value     = top_sym(i);
                            beat.last      = (i == n);
                            beat.exhausted = 1'b0;
                            expected_q.push_back(beat);
                        end
                        perms++;
                        return;
                    end
                    push_symbols(d, n);
                end else begin
                    // level empty: back up and drop the option just tried
                    if (d > 0) d = d - 1;
                    depth = d;
                    if (lvl_cnt[d] > 0) lvl_cnt[d] = lvl_cnt[d] - 4'd1;
                end
            end
            finished       = 1'b1;
            beat.value     = '0;
            beat.last      = 1'b1;
            beat.exhausted = 1'b1;
            expected_q.push_back(beat);
            exhausts++;
        endfunction

        function void check_result(logic [VAL_W-1:0] value, logic last, logic exhausted);
            perm_beat_t exp_beat;
            beats++;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: value %0d last %0b exhausted %0b",
                       value, last, exhausted);
                errors++;
                return;
            end
            exp_beat = expected_q.pop_front();
            if (value !== exp_beat.value) begin
                $error("m_value mismatch: expected %0d, actual %0d", exp_beat.value, value);
                errors++;
            end
            if (last !== exp_beat.last) begin
                $error("m_last mismatch: expected %0b, actual %0b", exp_beat.last, last);
                errors++;
            end
            if (exhausted !== exp_beat.exhausted) begin
                $error("m_exhausted mismatch: expected %0b, actual %0b",
                       exp_beat.exhausted, exhausted);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_set_size = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_restart    = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [VAL_W-1:0]  m_value;
    logic              m_last;
    logic              m_exhausted;

    perm_scoreboard sb;

    int sender_idle_pct = 0;   // chance per cycle that the sender holds back
    int recv_stall_pct  = 0;   // chance per cycle that the receiver stalls
    int hold_cnt        = 0;   // long receiver hold-off, counted down below

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    backtracking_permutation_generator_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_set_size(cfg_set_size),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_last      (m_last),
        .m_exhausted (m_exhausted)
    );

    // Receiver: ready changes on the falling edge. A pending hold-off wins
    // over the random stalls so the block backs up and drops s_ready.
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else begin
            m_ready <= !($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Result monitor: sample on the rising edge, before the DUT updates.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_value, m_last, m_exhausted);
    end

    // One request transfer; the sender may idle first. Valid is dropped only
    // when idling or between phases, never toggled within one time step.
    task automatic send_request(input bit rst);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= rst;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(rst);
    endtask

    // Let all expected transfers arrive with the request channel quiet.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Register write, only once the block has emptied out.
    task automatic write_set_size(input logic [SIZE_W-1:0] sz);
        drain();
        @(negedge aclk);
        cfg_valid    <= 1'b1;
        cfg_set_size <= sz;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(sz);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_pace(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [SIZE_W-1:0] phase_size [PHASES];
        int                p;
        int                k;
        bit                rst;

        // mix of sizes: tiny sets run into exhaustion, 0 and 15 hit the clamps
        phase_size = '{4'd4, 4'd2, 4'd8, 4'd1, 4'd15, 4'd5, 4'd3, 4'd0, 4'd6, 4'd7, 4'd3};
        phase_size[PHASES-1] = SIZE_W'($urandom_range(0, 15));
        sb = new();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset size 3 runs all six permutations from reset state,
        // then exhaustion repeats until a restart brings back 1 2 3.
        set_pace(0);
        repeat (6) send_request(1'b0);
        repeat (2) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // size 0 behaves like a single symbol
        write_set_size(4'd0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // 15 clamps to the largest set
        write_set_size(4'd15);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // Random phases: mostly continuing requests so the search walks deep
        // into the enumeration, with occasional restarts thrown in.
        for (p = 0; p < PHASES; p++) begin
            write_set_size(phase_size[p]);
            set_pace(p % 4);
            if (p == 2) hold_cnt = 400;   // receiver blocks while requests keep coming
            for (k = 0; k < PHASE_ITEMS; k++) begin
                rst = ($urandom_range(0, 99) < 6);
                send_request(rst);
            end
        end

        drain();
        repeat (40) @(posedge aclk);   // catch any stray transfer

        $display("Checked %0d result transfers for %0d requests (%0d with restart).",
                 sb.beats, sb.requests, sb.restarts);
        $display("%0d permutations, %0d exhausted replies, %0d set-size writes incl. 0 and 15.",
                 sb.perms, sb.exhausts, sb.cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
